// ===== hw/rtl/tpd_pkg.sv =====
// tpd_pkg: types, constants and register indexes for the touch press/tap detector
// used by every module under hw/rtl; no dependencies
package tpd_pkg;

  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 320;
  localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

  localparam int RAW_W      = 12;
  localparam int TIME_W     = 32;
  localparam int OUT_W      = 9;
  localparam int MS_W       = 16;
  localparam int RAD_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // quotient bits: the mapped coordinate before masking to the port width
  localparam int QW     = $clog2(SCREEN_MAX);
  localparam int NUM_W  = RAW_W + QW;
  localparam int CNT_W  = $clog2(QW + 1);
  localparam int SQ_W   = 2 * QW;
  localparam int CMP_W  = (SQ_W + 1 > 2 * RAD_W) ? SQ_W + 1 : 2 * RAD_W;
  localparam int QDEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_RAW_MIN     = 3'd0,
    CFG_X_RAW_MAX     = 3'd1,
    CFG_Y_RAW_MIN     = 3'd2,
    CFG_Y_RAW_MAX     = 3'd3,
    CFG_DEBOUNCE_MS   = 3'd4,
    CFG_HOLD_LIMIT_MS = 3'd5,
    CFG_TAP_RADIUS    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              touched;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] screen_x;
    logic [OUT_W-1:0] screen_y;
    logic             held;
    logic             press_event;
    logic             release_event;
    logic             tap_event;
    logic [OUT_W-1:0] tap_x;
    logic [OUT_W-1:0] tap_y;
  } out_t;

  typedef struct packed {
    logic [RAW_W-1:0] x_raw_min;
    logic [RAW_W-1:0] x_raw_max;
    logic [RAW_W-1:0] y_raw_min;
    logic [RAW_W-1:0] y_raw_max;
    logic [MS_W-1:0]  debounce_ms;
    logic [MS_W-1:0]  hold_limit_ms;
    logic [RAD_W-1:0] tap_radius;
  } cfg_t;

  // one axis of a classified sample
  typedef struct packed {
    logic             zero;
    logic             sat;
    logic [RAW_W-1:0] den;
    logic [NUM_W-1:0] num;
  } axis_job_t;

  typedef struct packed {
    logic              touched;
    logic [TIME_W-1:0] now_ms;
    axis_job_t         ax_x;
    axis_job_t         ax_y;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

// ===== hw/rtl/tpd_front.sv =====
// tpd_front: classifies one touch sample per axis and scales the raw offset
// depends on tpd_pkg
module tpd_front (
  input  tpd_pkg::in_t  in_req,
  input  tpd_pkg::cfg_t cfg,
  output tpd_pkg::job_t job
);

  function automatic tpd_pkg::axis_job_t classify(
    input logic [tpd_pkg::RAW_W-1:0] raw,
    input logic [tpd_pkg::RAW_W-1:0] lo,
    input logic [tpd_pkg::RAW_W-1:0] hi,
    input logic [tpd_pkg::NUM_W-1:0] size
  );
    tpd_pkg::axis_job_t a;
    logic [tpd_pkg::RAW_W-1:0] diff;
    diff   = raw - lo;
    a.zero = (hi <= lo) || (raw < lo);
    a.sat  = (raw >= hi);
    a.den  = hi - lo;
    a.num  = tpd_pkg::NUM_W'(diff) * size;
    return a;
  endfunction

  always_comb begin
    job.touched = in_req.touched;
    job.now_ms  = in_req.now_ms;
    job.ax_x    = classify(in_req.raw_x, cfg.x_raw_min, cfg.x_raw_max,
                           tpd_pkg::NUM_W'(tpd_pkg::SCREEN_WIDTH));
    job.ax_y    = classify(in_req.raw_y, cfg.y_raw_min, cfg.y_raw_max,
                           tpd_pkg::NUM_W'(tpd_pkg::SCREEN_HEIGHT));
  end

endmodule

// ===== hw/rtl/tpd_queue.sv =====
// tpd_queue: short fifo of classified samples between front and back
// depends on tpd_pkg
module tpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpd_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output tpd_pkg::job_t head
);

  localparam int PW = (tpd_pkg::QDEPTH > 1) ? $clog2(tpd_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(tpd_pkg::QDEPTH + 1);

  tpd_pkg::job_t mem_r [tpd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(tpd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_r == CW'(tpd_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/tpd_back.sv =====
// tpd_back: serial divider, press/release/tap state and the result register
// depends on tpd_pkg
module tpd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tpd_pkg::cfg_t cfg,
  input  logic          q_not_empty,
  input  tpd_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output tpd_pkg::out_t out_data
);

  localparam logic [tpd_pkg::QW-1:0] X_LAST = tpd_pkg::QW'(tpd_pkg::SCREEN_WIDTH - 1);
  localparam logic [tpd_pkg::QW-1:0] Y_LAST = tpd_pkg::QW'(tpd_pkg::SCREEN_HEIGHT - 1);
  localparam logic [tpd_pkg::CNT_W-1:0] STEP_LAST = tpd_pkg::CNT_W'(tpd_pkg::QW - 1);

  tpd_pkg::back_state_t state_r, state_nxt;

  tpd_pkg::job_t ent_r, ent_nxt;
  logic axis_r, axis_nxt;
  logic [tpd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tpd_pkg::RAW_W-1:0] rem_r, rem_nxt;
  logic [tpd_pkg::QW-1:0] quo_r, quo_nxt;
  logic [tpd_pkg::QW-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;

  logic pressed_r, pressed_nxt;
  logic [tpd_pkg::TIME_W-1:0] press_time_r, press_time_nxt;
  logic [tpd_pkg::TIME_W-1:0] release_time_r, release_time_nxt;
  logic [tpd_pkg::QW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [tpd_pkg::QW-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [tpd_pkg::SQ_W-1:0] dxsq_r, dysq_r;
  logic [2*tpd_pkg::RAD_W-1:0] rsq_r;

  logic out_valid_r, out_valid_nxt;
  tpd_pkg::out_t out_data_r, out_data_nxt;

  tpd_pkg::axis_job_t ax;
  logic out_free;
  logic shortcut;
  logic [tpd_pkg::RAW_W:0] trial;
  logic qbit;
  logic [tpd_pkg::QW-1:0] quo_step;
  logic [tpd_pkg::QW-1:0] dx_abs, dy_abs;
  logic commit;
  logic press_go;
  logic tap_ok;

  assign ax       = axis_r ? ent_r.ax_y : ent_r.ax_x;
  assign out_free = !out_valid_r || !out_stall;
  assign shortcut = ax.zero || ax.sat;
  assign trial    = {rem_r, quo_r[tpd_pkg::QW-1]};
  assign qbit     = (trial >= {1'b0, ax.den});
  assign quo_step = tpd_pkg::QW'({quo_r, qbit});
  assign commit   = (state_r == tpd_pkg::BK_EMIT) && out_free;
  assign dx_abs   = (cur_x_r >= start_x_r) ? cur_x_r - start_x_r : start_x_r - cur_x_r;
  assign dy_abs   = (cur_y_r >= start_y_r) ? cur_y_r - start_y_r : start_y_r - cur_y_r;
  assign press_go = !pressed_r &&
                    ((ent_r.now_ms - release_time_r) >= tpd_pkg::TIME_W'(cfg.debounce_ms));
  assign tap_ok   = ((ent_r.now_ms - press_time_r) < tpd_pkg::TIME_W'(cfg.hold_limit_ms)) &&
                    ((tpd_pkg::CMP_W'(dxsq_r) + tpd_pkg::CMP_W'(dysq_r)) <
                     tpd_pkg::CMP_W'(rsq_r));
  assign q_pop     = (state_r == tpd_pkg::BK_IDLE) && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpd_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_head.touched ? tpd_pkg::BK_LOAD : tpd_pkg::BK_EMIT;
        end
      end
      tpd_pkg::BK_LOAD: begin
        if (!shortcut) begin
          state_nxt = tpd_pkg::BK_DIV;
        end else if (axis_r) begin
          state_nxt = tpd_pkg::BK_EMIT;
        end
      end
      tpd_pkg::BK_DIV: begin
        if (cnt_r == STEP_LAST) begin
          state_nxt = axis_r ? tpd_pkg::BK_EMIT : tpd_pkg::BK_LOAD;
        end
      end
      tpd_pkg::BK_EMIT: begin
        if (out_free) begin
          state_nxt = tpd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tpd_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ent_nxt          = ent_r;
    axis_nxt         = axis_r;
    cnt_nxt          = cnt_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    res_x_nxt        = res_x_r;
    res_y_nxt        = res_y_r;
    pressed_nxt      = pressed_r;
    press_time_nxt   = press_time_r;
    release_time_nxt = release_time_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    start_x_nxt      = start_x_r;
    start_y_nxt      = start_y_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    case (state_r)
      tpd_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          ent_nxt  = q_head;
          axis_nxt = 1'b0;
        end
      end
      tpd_pkg::BK_LOAD: begin
        cnt_nxt = '0;
        rem_nxt = ax.num[tpd_pkg::NUM_W-1:tpd_pkg::QW];
        quo_nxt = ax.num[tpd_pkg::QW-1:0];
        if (shortcut) begin
          if (axis_r) begin
            res_y_nxt = ax.zero ? '0 : Y_LAST;
          end else begin
            res_x_nxt = ax.zero ? '0 : X_LAST;
          end
          axis_nxt = 1'b1;
        end
      end
      tpd_pkg::BK_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        rem_nxt = qbit ? tpd_pkg::RAW_W'(trial - {1'b0, ax.den})
                       : tpd_pkg::RAW_W'(trial);
        quo_nxt = quo_step;
        if (cnt_r == STEP_LAST) begin
          if (axis_r) begin
            res_y_nxt = quo_step;
          end else begin
            res_x_nxt = quo_step;
          end
          axis_nxt = 1'b1;
        end
      end
      tpd_pkg::BK_EMIT: begin
        if (commit) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.press_event   = 1'b0;
          out_data_nxt.release_event = 1'b0;
          out_data_nxt.tap_event     = 1'b0;
          out_data_nxt.tap_x         = '0;
          out_data_nxt.tap_y         = '0;
          if (ent_r.touched) begin
            cur_x_nxt = res_x_r;
            cur_y_nxt = res_y_r;
            if (press_go) begin
              pressed_nxt              = 1'b1;
              press_time_nxt           = ent_r.now_ms;
              start_x_nxt              = res_x_r;
              start_y_nxt              = res_y_r;
              out_data_nxt.press_event = 1'b1;
            end
          end else if (pressed_r) begin
            pressed_nxt                = 1'b0;
            release_time_nxt           = ent_r.now_ms;
            out_data_nxt.release_event = 1'b1;
            if (tap_ok) begin
              out_data_nxt.tap_event = 1'b1;
              out_data_nxt.tap_x     = tpd_pkg::OUT_W'(start_x_r);
              out_data_nxt.tap_y     = tpd_pkg::OUT_W'(start_y_r);
            end
          end
          out_data_nxt.screen_x = tpd_pkg::OUT_W'(cur_x_nxt);
          out_data_nxt.screen_y = tpd_pkg::OUT_W'(cur_y_nxt);
          out_data_nxt.held     = pressed_nxt;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tpd_pkg::BK_IDLE;
      axis_r         <= 1'b0;
      cnt_r          <= '0;
      pressed_r      <= 1'b0;
      press_time_r   <= '0;
      release_time_r <= '0;
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      axis_r         <= axis_nxt;
      cnt_r          <= cnt_nxt;
      pressed_r      <= pressed_nxt;
      press_time_r   <= press_time_nxt;
      release_time_r <= release_time_nxt;
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      start_x_r      <= start_x_nxt;
      start_y_r      <= start_y_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload and precomputed squares, no reset needed
  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    out_data_r <= out_data_nxt;
    dxsq_r     <= tpd_pkg::SQ_W'(dx_abs) * tpd_pkg::SQ_W'(dx_abs);
    dysq_r     <= tpd_pkg::SQ_W'(dy_abs) * tpd_pkg::SQ_W'(dy_abs);
    rsq_r      <= (2 * tpd_pkg::RAD_W)'(cfg.tap_radius) *
                  (2 * tpd_pkg::RAD_W)'(cfg.tap_radius);
  end

`ifndef SYNTHESIS
  a_div_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpd_pkg::BK_DIV) |-> (rem_r < ax.den))
    else $error("divider remainder not below divisor");

  a_tap_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.tap_event || out_data_r.release_event))
    else $error("tap without release");

  a_press_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.press_event) |->
    (out_data_r.held && !out_data_r.release_event))
    else $error("press event without held state");

  a_commit_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && ent_r.touched && press_go) |=> (pressed_r && out_valid_r))
    else $error("accepted press not recorded");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == tpd_pkg::BK_LOAD || state_r == tpd_pkg::BK_EMIT))
    else $error("pop did not start work");
`endif

endmodule

// ===== hw/rtl/touch_press_tap_detector.sv =====
// touch_press_tap_detector: top level with configuration registers, front, queue and back
// depends on tpd_pkg, tpd_front, tpd_queue, tpd_back
//
// One touch sample in, one result out. In the back end a touched sample takes two axis
// divisions of 9 iterations each on one shared restoring divider, plus the load and
// emit states; an axis whose raw reading is below min, at or above max, or whose
// calibration is degenerate skips its division. An untouched sample goes straight
// to the emit state. A two-entry queue lets the front take samples while the back is busy
// or its result waits. Registers are written with cfg_valid/cfg_ready (always ready)
// and must only change while the block is idle.
module touch_press_tap_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tpd_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tpd_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  tpd_pkg::cfg_t cfg_r, cfg_nxt;
  tpd_pkg::job_t front_job;
  tpd_pkg::job_t q_head;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (tpd_pkg::cfg_idx_t'(cfg_index))
        tpd_pkg::CFG_X_RAW_MIN:     cfg_nxt.x_raw_min     = tpd_pkg::RAW_W'(cfg_data);
        tpd_pkg::CFG_X_RAW_MAX:     cfg_nxt.x_raw_max     = tpd_pkg::RAW_W'(cfg_data);
        tpd_pkg::CFG_Y_RAW_MIN:     cfg_nxt.y_raw_min     = tpd_pkg::RAW_W'(cfg_data);
        tpd_pkg::CFG_Y_RAW_MAX:     cfg_nxt.y_raw_max     = tpd_pkg::RAW_W'(cfg_data);
        tpd_pkg::CFG_DEBOUNCE_MS:   cfg_nxt.debounce_ms   = tpd_pkg::MS_W'(cfg_data);
        tpd_pkg::CFG_HOLD_LIMIT_MS: cfg_nxt.hold_limit_ms = tpd_pkg::MS_W'(cfg_data);
        tpd_pkg::CFG_TAP_RADIUS:    cfg_nxt.tap_radius    = tpd_pkg::RAD_W'(cfg_data);
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_raw_min     <= tpd_pkg::RAW_W'(320);
      cfg_r.x_raw_max     <= tpd_pkg::RAW_W'(3900);
      cfg_r.y_raw_min     <= tpd_pkg::RAW_W'(240);
      cfg_r.y_raw_max     <= tpd_pkg::RAW_W'(3800);
      cfg_r.debounce_ms   <= tpd_pkg::MS_W'(50);
      cfg_r.hold_limit_ms <= tpd_pkg::MS_W'(600);
      cfg_r.tap_radius    <= tpd_pkg::RAD_W'(20);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tpd_front u_front (
    .in_req (in_data),
    .cfg    (cfg_r),
    .job    (front_job)
  );

  tpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tpd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// testbench for touch_press_tap_detector: drives touch samples and register writes, and
// predicts and checks every result; depends on tpd_pkg and the rtl under hw/rtl
module testbench;
  import tpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 30;

  class tap_scoreboard;
    cfg_t              regs;
    bit                is_held;
    logic [TIME_W-1:0] press_ms;
    logic [TIME_W-1:0] release_ms;
    int                cur_x;
    int                cur_y;
    int                start_x;
    int                start_y;
    out_t              expected_results[$];
    int                mismatch_count;

    function new();
      regs.x_raw_min = 320;
      regs.x_raw_max = 3900;
      regs.y_raw_min = 240;
      regs.y_raw_max = 3800;
      regs.debounce_ms = 50;
      regs.hold_limit_ms = 600;
      regs.tap_radius = 20;
      is_held = 1'b0;
      press_ms = '0;
      release_ms = '0;
      cur_x = 0;
      cur_y = 0;
      start_x = 0;
      start_y = 0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_X_RAW_MIN:     regs.x_raw_min = val[RAW_W-1:0];
        CFG_X_RAW_MAX:     regs.x_raw_max = val[RAW_W-1:0];
        CFG_Y_RAW_MIN:     regs.y_raw_min = val[RAW_W-1:0];
        CFG_Y_RAW_MAX:     regs.y_raw_max = val[RAW_W-1:0];
        CFG_DEBOUNCE_MS:   regs.debounce_ms = val[MS_W-1:0];
        CFG_HOLD_LIMIT_MS: regs.hold_limit_ms = val[MS_W-1:0];
        CFG_TAP_RADIUS:    regs.tap_radius = val[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // (raw - lo) * size / (hi - lo), truncated, then clamped to the screen
    function int scale_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                            logic [RAW_W-1:0] hi, int size);
      longint num;
      longint q;
      if (hi <= lo) return 0;
      num = (longint'(raw) - longint'(lo)) * size;
      q = num / (longint'(hi) - longint'(lo));
      if (q < 0) q = 0;
      if (q > size - 1) q = size - 1;
      return int'(q);
    endfunction

    function void note_sample(in_t s);
      out_t              r;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] hold;
      int                dx;
      int                dy;
      int                rad;
      r = '0;
      if (s.touched) begin
        cur_x = scale_axis(s.raw_x, regs.x_raw_min, regs.x_raw_max, SCREEN_WIDTH);
        cur_y = scale_axis(s.raw_y, regs.y_raw_min, regs.y_raw_max, SCREEN_HEIGHT);
        gap = s.now_ms - release_ms;
        if (!is_held && gap >= TIME_W'(regs.debounce_ms)) begin
          is_held = 1'b1;
          press_ms = s.now_ms;
          start_x = cur_x;
          start_y = cur_y;
          r.press_event = 1'b1;
        end
      end else if (is_held) begin
        hold = s.now_ms - press_ms;
        dx = cur_x - start_x;
        dy = cur_y - start_y;
        rad = int'(regs.tap_radius);
        is_held = 1'b0;
        release_ms = s.now_ms;
        r.release_event = 1'b1;
        if (hold < TIME_W'(regs.hold_limit_ms) && dx * dx + dy * dy < rad * rad) begin
          r.tap_event = 1'b1;
          r.tap_x = OUT_W'(start_x);
          r.tap_y = OUT_W'(start_y);
        end
      end
      r.screen_x = OUT_W'(cur_x);
      r.screen_y = OUT_W'(cur_y);
      r.held = is_held;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch on %s at %0t: expected %0d, got %0d", name, $time, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with no request pending at %0t", $time);
        return;
      end
      want = expected_results.pop_front();
      compare_field("screen_x", want.screen_x, got.screen_x);
      compare_field("screen_y", want.screen_y, got.screen_y);
      compare_field("held", OUT_W'(want.held), OUT_W'(got.held));
      compare_field("press_event", OUT_W'(want.press_event), OUT_W'(got.press_event));
      compare_field("release_event", OUT_W'(want.release_event), OUT_W'(got.release_event));
      compare_field("tap_event", OUT_W'(want.tap_event), OUT_W'(got.tap_event));
      compare_field("tap_x", want.tap_x, got.tap_x);
      compare_field("tap_y", want.tap_y, got.tap_y);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tap_scoreboard     board;
  bit                quiet_run;
  logic [TIME_W-1:0] clock_ms;
  int                sample_count;

  touch_press_tap_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function int idle_draw();
    return quiet_run ? 0 : $urandom_range(0, 12);
  endfunction

  function in_t make_sample(bit touched, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                            logic [TIME_W-1:0] ms);
    in_t s;
    s.touched = touched;
    s.raw_x = rx;
    s.raw_y = ry;
    s.now_ms = ms;
    return s;
  endfunction

  // time offsets clustered around a threshold, with some far off
  function logic [TIME_W-1:0] gap_near(logic [TIME_W-1:0] th);
    case ($urandom_range(0, 6))
      0: return th;
      1: return (th == 0) ? th : th - 1;
      2: return th + 1;
      3: return $urandom_range(0, th);
      4: return th + $urandom_range(0, 200);
      5: return $urandom;
      default: return $urandom_range(0, 30);
    endcase
  endfunction

  function logic [RAW_W-1:0] wobble(logic [RAW_W-1:0] c, int j);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * j)) - j;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return RAW_W'(v);
  endfunction

  task automatic send_sample(input in_t s);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = s;
    do @(posedge clk); while (in_stall);
    board.note_sample(s);
    sample_count++;
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] x_lo, input logic [15:0] x_hi,
                           input logic [15:0] y_lo, input logic [15:0] y_hi,
                           input logic [15:0] deb, input logic [15:0] lng,
                           input logic [15:0] rad);
    write_reg(CFG_X_RAW_MIN, x_lo);
    write_reg(CFG_X_RAW_MAX, x_hi);
    write_reg(CFG_Y_RAW_MIN, y_lo);
    write_reg(CFG_Y_RAW_MAX, y_hi);
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_HOLD_LIMIT_MS, lng);
    write_reg(CFG_TAP_RADIUS, rad);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  task automatic program_phase(input int phase);
    logic [11:0] xl;
    logic [11:0] yl;
    xl = 12'($urandom_range(0, 3000));
    yl = 12'($urandom_range(0, 3000));
    case (phase)
      0: write_all(16'd0, 16'hFFFF, 16'hF000, 16'h0FFF, 16'd0, 16'd0, 16'd0);
      // reversed and equal calibration give a constant zero coordinate
      1: write_all(16'd4095, 16'd0, 16'd2048, 16'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      2: write_all(16'd0, 16'd1, 16'd4094, 16'd4095, 16'd1, 16'd1, 16'd1);
      3: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
      default: write_all({4'($urandom), xl}, {4'($urandom), xl + 12'($urandom_range(1, 4095 - xl))},
                         {4'($urandom), yl}, {4'($urandom), yl + 12'($urandom_range(1, 4095 - yl))},
                         16'($urandom_range(0, 200)), 16'($urandom_range(0, 1500)),
                         {8'($urandom), 8'($urandom_range(0, 255))});
    endcase
  endtask

  task automatic run_directed();
    send_sample(make_sample(1'b1, 12'd0, 12'd0, 32'd10));
    send_sample(make_sample(1'b0, 12'd7, 12'd9, 32'd20));
    send_sample(make_sample(1'b1, 12'd4095, 12'd4095, 32'd100));
    send_sample(make_sample(1'b1, 12'd4095, 12'd4095, 32'd150));
    send_sample(make_sample(1'b0, 12'd0, 12'd0, 32'd200));
    send_sample(make_sample(1'b1, 12'd320, 12'd240, 32'd249));
    send_sample(make_sample(1'b1, 12'd3900, 12'd3800, 32'd250));
    send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 32'd400));
    send_sample(make_sample(1'b0, 12'd2000, 12'd2000, 32'd500));
    send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 32'd550));
    send_sample(make_sample(1'b0, 12'd2000, 12'd2000, 32'd1150));
    send_sample(make_sample(1'b1, 12'd2100, 12'd2100, 32'd1200));
    send_sample(make_sample(1'b1, 12'd2240, 12'd2100, 32'd1300));
    send_sample(make_sample(1'b0, 12'd2240, 12'd2100, 32'd1799));
    send_sample(make_sample(1'b1, 12'd4095, 12'd0, 32'hFFFF_FFF0));
    send_sample(make_sample(1'b1, 12'd0, 12'd4095, 32'hFFFF_FFFF));
    send_sample(make_sample(1'b0, 12'hAAA, 12'h555, 32'h0000_0020));
    send_sample(make_sample(1'b1, 12'd1234, 12'd2345, 32'h0000_0051));
    send_sample(make_sample(1'b1, 12'd1234, 12'd2345, 32'h0000_0052));
    send_sample(make_sample(1'b0, 12'h555, 12'hAAA, 32'h0000_0060));
    send_sample(make_sample(1'b0, 12'hFFF, 12'hFFF, 32'hAAAA_5555));
    send_sample(make_sample(1'b1, 12'hA5A, 12'h5A5, 32'h5555_AAAA));
    send_sample(make_sample(1'b0, 12'h5A5, 12'hA5A, 32'h5555_AAAB));
    clock_ms = 32'h5555_AAAB;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 100);
    send_sample(make_sample(1'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                            clock_ms));
  endtask

  // press, a few moves, release, timed around the debounce and long press thresholds
  task automatic play_gesture();
    logic [RAW_W-1:0]  px;
    logic [RAW_W-1:0]  py;
    logic [TIME_W-1:0] t_press;
    logic [TIME_W-1:0] span;
    int                jitter;
    int                steps;
    px = RAW_W'($urandom);
    py = RAW_W'($urandom);
    jitter = $urandom_range(0, 400);
    steps = $urandom_range(0, 4);
    clock_ms += gap_near(TIME_W'(board.regs.debounce_ms));
    t_press = clock_ms;
    send_sample(make_sample(1'b1, px, py, clock_ms));
    span = gap_near(TIME_W'(board.regs.hold_limit_ms));
    for (int k = 1; k <= steps; k++) begin
      clock_ms = t_press + TIME_W'(longint'(span) * k / (steps + 1));
      send_sample(make_sample(1'b1, wobble(px, jitter), wobble(py, jitter), clock_ms));
    end
    clock_ms = t_press + span;
    send_sample(make_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom), clock_ms));
  endtask

  task automatic run_random_phase(input bit pause_midway);
    int first;
    first = sample_count;
    while (sample_count - first < PHASE_ITEMS) begin
      quiet_run = ($urandom_range(0, 4) == 0);
      if (pause_midway && sample_count - first >= PHASE_ITEMS / 2) begin
        drain_results();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) send_noise();
      else play_gesture();
    end
  endtask

  // result side: stall each result for a random number of valid cycles
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid) begin
        if (!out_stall) begin
          board.check_result(out_data);
          stall_left = idle_draw();
        end else if (stall_left > 0) begin
          stall_left--;
        end
      end
      @(negedge clk);
      out_stall = (stall_left > 0);
    end
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_run = 1'b0;
    clock_ms = '0;
    sample_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    drain_results();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      program_phase(phase);
      run_random_phase(phase == 0);
      drain_results();
    end
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_front.sv
hw/rtl/tpd_queue.sv
hw/rtl/tpd_back.sv
hw/rtl/touch_press_tap_detector.sv
dv/testbench.sv
